// File: sv/upsc_pkg.sv
// shared constants and types of the integer pixel upscaler
package upsc_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_SCALE_DEF = 100;

  localparam int SCALE_W    = 7;
  localparam int WIDTH_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int PIX_W      = 24;

  localparam int REQ_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 1'b1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef enum logic [1:0] {
    REQ_LOAD,
    REQ_PIXEL,
    REQ_ERROR
  } req_kind_e;

  typedef struct packed {
    req_kind_e  kind;
    logic       row_end;
    logic [1:0] pad;
    logic       done;
  } req_meta_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic [1:0] pad;
    logic       done;
    logic       error;
  } result_t;

endpackage

// File: sv/upsc_front.sv
// front part: config registers, item classification and row counters
module upsc_front #(
  parameter int MAX_WIDTH = upsc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE = upsc_pkg::MAX_SCALE_DEF,
  parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [upsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [upsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             push_i,
  input  logic                             full_i,
  input  logic                             command_i,
  input  logic [upsc_pkg::PIX_W-1:0]       pix_i,
  output logic                             req_push_o,
  output upsc_pkg::req_meta_t              req_meta_o,
  output logic [AW-1:0]                    req_addr_o,
  output logic [upsc_pkg::PIX_W-1:0]       req_pix_o
);

  localparam int MWB = $clog2(MAX_WIDTH + 1);
  localparam int WCW = (MWB > upsc_pkg::WIDTH_W) ? MWB : upsc_pkg::WIDTH_W;
  localparam int MSB = $clog2(MAX_SCALE + 1);
  localparam int SCW = (MSB > upsc_pkg::SCALE_W) ? MSB : upsc_pkg::SCALE_W;

  logic [upsc_pkg::SCALE_W-1:0] scale_q, scale_d;
  logic [upsc_pkg::WIDTH_W-1:0] width_q, width_d;
  logic [WCW-1:0]               load_count_q, load_count_d;
  logic [AW-1:0]                read_index_q, read_index_d;
  logic [SCW-1:0]               hrep_q, hrep_d;
  logic [SCW-1:0]               vrep_q, vrep_d;
  logic                         row_ready_q, row_ready_d;

  logic [WCW-1:0] width_x, eff_w, lc_inc;
  logic [SCW-1:0] scale_x, eff_s;
  logic           accept, h_last, r_last, v_last;
  logic [1:0]     prod, prod3;

  // effective limits
  always_comb begin
    width_x = WCW'(width_q);
    scale_x = SCW'(scale_q);
    if (width_q == '0) begin
      eff_w = WCW'(1);
    end else if (width_x > WCW'(MAX_WIDTH)) begin
      eff_w = WCW'(MAX_WIDTH);
    end else begin
      eff_w = width_x;
    end
    if (scale_q == '0) begin
      eff_s = SCW'(1);
    end else if (scale_x > SCW'(MAX_SCALE)) begin
      eff_s = SCW'(MAX_SCALE);
    end else begin
      eff_s = scale_x;
    end
  end

  // config writes
  always_comb begin
    scale_d = scale_q;
    width_d = width_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        upsc_pkg::CFG_SCALE: scale_d = cfg_data_i[upsc_pkg::SCALE_W-1:0];
        upsc_pkg::CFG_WIDTH: width_d = cfg_data_i[upsc_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = push_i && !full_i;
  assign lc_inc = load_count_q + WCW'(1);
  assign h_last = ({1'b0, hrep_q} + (SCW+1)'(1)) >= {1'b0, eff_s};
  assign r_last = ((WCW+1)'(read_index_q) + (WCW+1)'(1)) >= {1'b0, eff_w};
  assign v_last = ({1'b0, vrep_q} + (SCW+1)'(1)) >= {1'b0, eff_s};

  // padding of 3 * w * s bytes to a multiple of four
  assign prod  = 2'(eff_w[1:0] * eff_s[1:0]);
  assign prod3 = 2'({2'b00, prod} * 4'd3);

  always_comb begin
    load_count_d = load_count_q;
    read_index_d = read_index_q;
    hrep_d       = hrep_q;
    vrep_d       = vrep_q;
    row_ready_d  = row_ready_q;
    req_meta_o   = '{kind: upsc_pkg::REQ_ERROR, row_end: 1'b0, pad: 2'd0, done: 1'b0};
    req_addr_o   = read_index_q;
    req_pix_o    = pix_i;
    if (command_i == upsc_pkg::CMD_LOAD) begin
      if (!(row_ready_q || load_count_q >= eff_w)) begin
        req_meta_o.kind = upsc_pkg::REQ_LOAD;
        req_addr_o      = load_count_q[AW-1:0];
        if (accept) begin
          load_count_d = lc_inc;
          row_ready_d  = lc_inc >= eff_w;
        end
      end
    end else if (row_ready_q) begin
      req_meta_o.kind = upsc_pkg::REQ_PIXEL;
      if (h_last) begin
        if (r_last) begin
          req_meta_o.row_end = 1'b1;
          req_meta_o.pad     = 2'(3'd4 - {1'b0, prod3});
          req_meta_o.done    = v_last;
        end
      end
      if (accept) begin
        if (h_last) begin
          hrep_d = '0;
          if (r_last) begin
            read_index_d = '0;
            if (v_last) begin
              vrep_d       = '0;
              row_ready_d  = 1'b0;
              load_count_d = '0;
            end else begin
              vrep_d = vrep_q + SCW'(1);
            end
          end else begin
            read_index_d = read_index_q + AW'(1);
          end
        end else begin
          hrep_d = hrep_q + SCW'(1);
        end
      end
    end
  end

  assign req_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q      <= upsc_pkg::SCALE_W'(1);
      width_q      <= upsc_pkg::WIDTH_W'(1);
      load_count_q <= '0;
      read_index_q <= '0;
      hrep_q       <= '0;
      vrep_q       <= '0;
      row_ready_q  <= 1'b0;
    end else begin
      scale_q      <= scale_d;
      width_q      <= width_d;
      load_count_q <= load_count_d;
      read_index_q <= read_index_d;
      hrep_q       <= hrep_d;
      vrep_q       <= vrep_d;
      row_ready_q  <= row_ready_d;
    end
  end

  a_err_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_meta_o.kind == upsc_pkg::REQ_ERROR) |=>
      ($stable(load_count_q) && $stable(read_index_q) && $stable(row_ready_q)))
    else $error("rejected item changed row state");

  a_load_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_meta_o.kind == upsc_pkg::REQ_LOAD) |-> !row_ready_q)
    else $error("load accepted into a ready row");

endmodule

// File: sv/upsc_queue.sv
// short request queue between the front and back parts
module upsc_queue #(
  parameter int AW = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  upsc_pkg::req_meta_t        meta_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [upsc_pkg::PIX_W-1:0] pix_i,
  output logic                       full_o,
  output logic                       empty_o,
  input  logic                       pop_i,
  output upsc_pkg::req_meta_t        meta_o,
  output logic [AW-1:0]              addr_o,
  output logic [upsc_pkg::PIX_W-1:0] pix_o
);

  localparam int DEPTH = upsc_pkg::REQ_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  upsc_pkg::req_meta_t        meta_q [DEPTH];
  logic [AW-1:0]              addr_q [DEPTH];
  logic [upsc_pkg::PIX_W-1:0] pix_q  [DEPTH];
  logic [PW-1:0]              head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic                       do_push, do_pop;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  assign meta_o = meta_q[head_q];
  assign addr_o = addr_q[head_q];
  assign pix_o  = pix_q[head_q];

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      tail_d = (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);
    end
    if (do_pop) begin
      head_d = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      meta_q[tail_q] <= meta_i;
      addr_q[tail_q] <= addr_i;
      pix_q[tail_q]  <= pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: sv/upsc_back.sv
// back part: line buffer access, result build and result queue
module upsc_back #(
  parameter int MAX_WIDTH = upsc_pkg::MAX_WIDTH_DEF,
  parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_empty_i,
  input  upsc_pkg::req_meta_t        req_meta_i,
  input  logic [AW-1:0]              req_addr_i,
  input  logic [upsc_pkg::PIX_W-1:0] req_pix_i,
  output logic                       req_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output upsc_pkg::result_t          result_o
);

  localparam int DEPTH = upsc_pkg::OUT_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [upsc_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [upsc_pkg::PIX_W-1:0] rd_q;
  logic                       s1_valid_q;
  upsc_pkg::req_meta_t        s1_meta_q;
  upsc_pkg::result_t          res;
  upsc_pkg::result_t          out_q [DEPTH];
  logic [PW-1:0]              head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic                       do_pop;

  // issue only with room reserved for the item in flight
  assign req_pop_o = !req_empty_i &&
                     (({1'b0, cnt_q} + (CW+1)'(s1_valid_q)) < (CW+1)'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (req_pop_o && req_meta_i.kind == upsc_pkg::REQ_LOAD) begin
      line_mem[req_addr_i] <= req_pix_i;
    end
    if (req_pop_o && req_meta_i.kind == upsc_pkg::REQ_PIXEL) begin
      rd_q <= line_mem[req_addr_i];
    end
    if (req_pop_o) begin
      s1_meta_q <= req_meta_i;
    end
  end

  always_comb begin
    res = '0;
    case (s1_meta_q.kind)
      upsc_pkg::REQ_PIXEL: begin
        res.pixel_valid = 1'b1;
        res.blue        = rd_q[7:0];
        res.green       = rd_q[15:8];
        res.red         = rd_q[23:16];
        res.row_end     = s1_meta_q.row_end;
        res.pad         = s1_meta_q.pad;
        res.done        = s1_meta_q.done;
      end
      upsc_pkg::REQ_ERROR: res.error = 1'b1;
      default: ;
    endcase
  end

  assign empty_o  = cnt_q == '0;
  assign do_pop   = pop_i && !empty_o;
  assign result_o = out_q[head_q];

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (s1_valid_q) begin
      tail_d = (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);
    end
    if (do_pop) begin
      head_d = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
    end
    if (s1_valid_q && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !s1_valid_q) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      out_q[tail_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= req_pop_o;
      head_q     <= head_d;
      tail_q     <= tail_d;
      cnt_q      <= cnt_d;
    end
  end

  a_room_for_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (cnt_q < CW'(DEPTH)))
    else $error("result queue overrun");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_pop_o && s1_valid_q) |-> (cnt_q < CW'(DEPTH - 1)))
    else $error("issued without reserved room");

endmodule

// File: sv/integer_pixel_upscaler.sv
// top level of the nearest-neighbor integer pixel upscaler
//
// input channel: push/full, one item per clock while full is low; command 0
// loads a source pixel into the line buffer, command 1 fetches the next output pixel
// result channel: empty/pop, every input item yields exactly one result,
// in order; the oldest result sits on the result ports while empty is low
// config: cfg_we_i writes scale_factor (index 0) or source_width (index 1)
// at the clock edge; the user must write only while the block is idle (not enforced)
// throughput: one item per clock while full is low, set by the single line buffer port
// an accepted item passes the request queue, the registered buffer read
// and the result queue before its result shows on the result ports
// when pop stays low, the result queue (4) and the request queue (2)
// fill up, six items wait and full rises; nothing is dropped
// reset clears all counters and queues and sets both registers to 1;
// the line buffer contents are not cleared and read as junk until written
module integer_pixel_upscaler #(
  parameter int MAX_WIDTH = upsc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE = upsc_pkg::MAX_SCALE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [upsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [upsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic                            command_i,
  input  logic [7:0]                      in_blue_i,
  input  logic [7:0]                      in_green_i,
  input  logic [7:0]                      in_red_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            pixel_valid_o,
  output logic [7:0]                      out_blue_o,
  output logic [7:0]                      out_green_o,
  output logic [7:0]                      out_red_o,
  output logic                            row_end_o,
  output logic [1:0]                      pad_bytes_o,
  output logic                            row_replays_done_o,
  output logic                            error_flag_o
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                       req_push, req_empty, req_pop;
  upsc_pkg::req_meta_t        front_meta, q_meta;
  logic [AW-1:0]              front_addr, q_addr;
  logic [upsc_pkg::PIX_W-1:0] front_pix, q_pix;
  upsc_pkg::result_t          result;

  upsc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE),
    .AW        (AW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .full_i     (full),
    .command_i  (command_i),
    .pix_i      ({in_red_i, in_green_i, in_blue_i}),
    .req_push_o (req_push),
    .req_meta_o (front_meta),
    .req_addr_o (front_addr),
    .req_pix_o  (front_pix)
  );

  upsc_queue #(
    .AW (AW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_push),
    .meta_i  (front_meta),
    .addr_i  (front_addr),
    .pix_i   (front_pix),
    .full_o  (full),
    .empty_o (req_empty),
    .pop_i   (req_pop),
    .meta_o  (q_meta),
    .addr_o  (q_addr),
    .pix_o   (q_pix)
  );

  upsc_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_empty_i (req_empty),
    .req_meta_i  (q_meta),
    .req_addr_i  (q_addr),
    .req_pix_i   (q_pix),
    .req_pop_o   (req_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result)
  );

  assign pixel_valid_o      = result.pixel_valid;
  assign out_blue_o         = result.blue;
  assign out_green_o        = result.green;
  assign out_red_o          = result.red;
  assign row_end_o          = result.row_end;
  assign pad_bytes_o        = result.pad;
  assign row_replays_done_o = result.done;
  assign error_flag_o       = result.error;

endmodule
